// ----- rtl/sli_pkg.sv -----
// ----------------------------------------------------------------------------
// sli_pkg: shared types and codes of the sorted list core
// Opcodes, status codes and the command/result transaction structs.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int unsigned HANDLE_W = 8;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned COUNT_W  = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic                opcode;
        logic [HANDLE_W-1:0] item_handle;
        logic [KEY_W-1:0]    sort_key;
    } t_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0]  entry_count;
        logic [1:0]          status;
        logic                head_valid;
        logic [HANDLE_W-1:0] head_handle;
        logic [KEY_W-1:0]    head_key;
    } t_rsp;

endpackage

// ----- rtl/sli_ram.sv -----
// ----------------------------------------------------------------------------
// sli_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sli_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/sorted_list_insert_remove_core.sv -----
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_core: bounded ascending-key list of entries
// Insert keeps ties in arrival order; remove deletes by handle.
// ----------------------------------------------------------------------------
// channel | direction | handshake         | payload
// command | in        | i_start & !o_busy | i_cmd (t_cmd)
// result  | out       | o_done strobe     | o_rsp (t_rsp)
//
// A transaction runs from acceptance through the o_done cycle: a scan
// reads the list to find the handle and the insert slot; on success a
// shift pass moves entries one at a time (read, then write back), and the
// head copy is reread from entry 0. o_busy holds through the o_done cycle.
// No clearing pass: only written entries are read. The receiver cannot
// stall; o_done lasts one cycle.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sli_pkg::t_cmd     i_cmd,
    output logic              o_busy,
    output logic              o_done,
    output sli_pkg::t_rsp     o_rsp
);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = sli_pkg::HANDLE_W + sli_pkg::KEY_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DEC   = 6'b000100,
        S_SHIFT = 6'b001000,
        S_HEAD  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    sli_pkg::t_cmd        r_cmd;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;      // scan/shift index
    logic                 r_rv, n_rv;        // read data valid this cycle
    logic [CW-1:0]        r_ridx, n_ridx;    // index of the data being returned
    logic [CW-1:0]        r_pos, n_pos;      // insert slot / remove position
    logic                 r_pos_set, n_pos_set;
    logic                 r_found, n_found;
    logic [1:0]           r_status, n_status;
    logic [EW-1:0]        r_head, n_head;

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [EW-1:0]        wdata, rdata;
    logic [sli_pkg::HANDLE_W-1:0] rd_h;
    logic [sli_pkg::KEY_W-1:0]    rd_k;

    sli_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rd_h = rdata[EW-1 -: sli_pkg::HANDLE_W];
    assign rd_k = rdata[sli_pkg::KEY_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rv      = 1'b0;
        n_ridx    = r_ridx;
        n_pos     = r_pos;
        n_pos_set = r_pos_set;
        n_found   = r_found;
        n_status  = r_status;
        n_head    = r_head;
        we        = 1'b0;
        waddr     = r_idx[AW-1:0];
        wdata     = rdata;
        raddr     = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                n_idx     = '0;
                n_pos     = r_count;
                n_pos_set = 1'b0;
                n_found   = 1'b0;
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue reads while index below count and no handle match, then drain last read
                if (r_idx < r_count && !r_found) begin
                    n_rv   = 1'b1;
                    n_ridx = r_idx;
                    n_idx  = r_idx + 1'b1;
                end
                if (r_rv) begin
                    if (rd_h == r_cmd.item_handle && !r_found) begin
                        n_found = 1'b1;
                        if (r_cmd.opcode == sli_pkg::OP_REMOVE) begin
                            n_pos = r_ridx;
                        end
                    end
                    if (r_cmd.opcode == sli_pkg::OP_INSERT && !r_pos_set
                            && rd_k > r_cmd.sort_key) begin
                        n_pos     = r_ridx;
                        n_pos_set = 1'b1;
                    end
                end
                if (!(r_idx < r_count && !r_found) && !r_rv) begin
                    n_state = S_DEC;
                end else if (r_rv && rd_h == r_cmd.item_handle) begin
                    n_rv = 1'b0;  // early stop; drop in-flight read
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_rv = 1'b0;
                if (r_cmd.opcode == sli_pkg::OP_INSERT) begin
                    if (r_found) begin
                        n_status = sli_pkg::ST_DUP;
                        n_state  = S_DONE;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_status = sli_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_status = sli_pkg::ST_OK;
                        n_idx    = r_count;   // shift down from the tail
                        n_state  = S_SHIFT;
                    end
                end else begin
                    if (!r_found) begin
                        n_status = sli_pkg::ST_MISSING;
                        n_state  = S_DONE;
                    end else begin
                        n_status = sli_pkg::ST_OK;
                        n_idx    = r_pos;
                        n_state  = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (r_cmd.opcode == sli_pkg::OP_INSERT) begin
                    // at idx: entry[idx] <= entry[idx-1], read then write
                    if (r_idx == r_pos) begin
                        we      = 1'b1;
                        waddr   = r_idx[AW-1:0];
                        wdata   = {r_cmd.item_handle, r_cmd.sort_key};
                        n_count = r_count + 1'b1;
                        n_state = S_HEAD;
                    end else if (!r_rv) begin
                        raddr  = AW'(r_idx - 1'b1);
                        n_rv   = 1'b1;
                    end else begin
                        we    = 1'b1;
                        waddr = r_idx[AW-1:0];
                        n_idx = r_idx - 1'b1;
                    end
                end else begin
                    // at idx: entry[idx] <= entry[idx+1]
                    if (r_idx + 1'b1 >= r_count) begin
                        n_count = r_count - 1'b1;
                        n_state = S_HEAD;
                    end else if (!r_rv) begin
                        raddr = AW'(r_idx + 1'b1);
                        n_rv  = 1'b1;
                    end else begin
                        we    = 1'b1;
                        waddr = r_idx[AW-1:0];
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_HEAD: begin
                // refresh head copy from entry 0
                raddr = '0;
                if (r_rv) begin
                    n_head  = rdata;
                    n_state = S_DONE;
                end else if (r_count == '0) begin
                    n_head  = '0;
                    n_state = S_DONE;
                end else begin
                    n_rv = 1'b1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rv    <= 1'b0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rv    <= n_rv;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cmd <= i_cmd;
        end
        r_idx     <= n_idx;
        r_ridx    <= n_ridx;
        r_pos     <= n_pos;
        r_pos_set <= n_pos_set;
        r_found   <= n_found;
        r_status  <= n_status;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_rsp             = '0;
        o_rsp.entry_count = sli_pkg::COUNT_W'(r_count);
        o_rsp.status      = r_status;
        o_rsp.head_valid  = (r_count != '0);
        if (r_count != '0) begin
            o_rsp.head_handle = r_head[EW-1 -: sli_pkg::HANDLE_W];
            o_rsp.head_key    = r_head[sli_pkg::KEY_W-1:0];
        end
    end

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count above capacity");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");
    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != sli_pkg::ST_OK) |-> $stable(r_count))
        else $error("failed transaction changed count");
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> r_state == S_SHIFT) else $error("write outside shift");
`endif
endmodule
